// File: rtl/core/mail_header_field_tokenizer_core_assert.svh
// Assertion macros shared by the tokenizer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef MAIL_HEADER_FIELD_TOKENIZER_CORE_ASSERT_SVH
`define MAIL_HEADER_FIELD_TOKENIZER_CORE_ASSERT_SVH

// same-cycle implication
`define MHFT_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// next-cycle implication
`define MHFT_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

// File: rtl/core/mhft_pkg.sv
// Package for the mail header field tokenizer: codes, types, byte decode
// and the per-byte classification step. No dependencies.
package mhft_pkg;

  // queue depths (power of two)
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [2:0] M_START      = 3'd0;
  localparam logic [2:0] M_LABEL      = 3'd1;
  localparam logic [2:0] M_SKIP       = 3'd2;
  localparam logic [2:0] M_VALUE      = 3'd3;
  localparam logic [2:0] M_DISCARD    = 3'd4;
  localparam logic [2:0] M_DISCARD_LF = 3'd5;

  localparam logic [2:0] C_LABEL   = 3'd0;
  localparam logic [2:0] C_COLON   = 3'd1;
  localparam logic [2:0] C_SKIP    = 3'd2;
  localparam logic [2:0] C_VALUE   = 3'd3;
  localparam logic [2:0] C_ESCAPE  = 3'd4;
  localparam logic [2:0] C_FOLD    = 3'd5;
  localparam logic [2:0] C_LINEEND = 3'd6;
  localparam logic [2:0] C_BAD     = 3'd7;

  typedef struct packed {
    logic ws;      // space, tab, LF, VT, FF, CR
    logic blank;   // space or tab
    logic cr;
    logic lf;
    logic colon;
    logic quote;
    logic bslash;
  } char_flags_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        end_flag;
    char_flags_t flags;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       quoted;
    logic       esc;
    logic       prev_colon;
  } parse_state_t;

  localparam parse_state_t ST_RESET = parse_state_t'{M_START, 1'b0, 1'b0, 1'b0};

  typedef struct packed {
    parse_state_t st;
    logic [2:0]   cls;
    logic         done;
  } class_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] cls;
    logic       done;
    logic       last;
  } result_t;

  function automatic char_flags_t decode_char(logic [7:0] b);
    char_flags_t f;
    f.blank  = (b == CH_SPACE) || (b == CH_TAB);
    f.cr     = (b == CH_CR);
    f.lf     = (b == CH_LF);
    f.ws     = f.blank || f.cr || f.lf || (b == CH_VT) || (b == CH_FF);
    f.colon  = (b == CH_COLON);
    f.quote  = (b == CH_QUOTE);
    f.bslash = (b == CH_BSLASH);
    return f;
  endfunction

  // One byte through the line parser; mode hops within the same byte are
  // resolved by falling through the blocks in order.
  function automatic class_result_t classify(parse_state_t st_in, char_flags_t b,
                                             logic has_next, char_flags_t nx);
    parse_state_t  st;
    logic [2:0]    cls;
    logic          done;
    logic          settled;
    logic          lf_end;
    class_result_t r;
    st      = st_in;
    cls     = C_BAD;
    done    = 1'b0;
    settled = 1'b0;
    lf_end  = 1'b0;

    if (st.mode == M_DISCARD_LF) begin
      if (b.lf) begin
        cls     = C_LINEEND;
        done    = 1'b1;
        st.mode = M_START;
        settled = 1'b1;
      end else begin
        st.mode = M_START;
      end
    end

    if (!settled && (st.mode == M_START || st.mode > M_DISCARD_LF)) begin
      st.quoted     = 1'b0;
      st.esc        = 1'b0;
      st.prev_colon = 1'b0;
      st.mode       = b.ws ? M_DISCARD : M_LABEL;
    end

    if (!settled && st.mode == M_LABEL) begin
      if (st.quoted) begin
        if (st.esc) begin
          st.esc = 1'b0;
          cls    = C_LABEL;
        end else if (b.bslash) begin
          st.esc = 1'b1;
          cls    = C_ESCAPE;
        end else begin
          if (b.quote) st.quoted = 1'b0;
          cls = C_LABEL;
        end
        st.prev_colon = b.colon;
        settled       = 1'b1;
      end else if (b.ws) begin
        st.mode = st.prev_colon ? M_SKIP : M_DISCARD;
      end else begin
        if (b.quote) st.quoted = 1'b1;
        cls           = (b.colon && (!has_next || nx.ws)) ? C_COLON : C_LABEL;
        st.prev_colon = b.colon;
        settled       = 1'b1;
      end
    end

    if (!settled && st.mode == M_SKIP) begin
      if (b.blank || b.cr) begin
        cls     = C_SKIP;
        settled = 1'b1;
      end else if (b.lf) begin
        lf_end  = 1'b1;
        settled = 1'b1;
      end else begin
        st.mode = M_VALUE;
      end
    end

    if (!settled && st.mode == M_VALUE) begin
      if (st.esc) begin
        st.esc = 1'b0;
        cls    = C_VALUE;
      end else if (b.bslash) begin
        st.esc = 1'b1;
        cls    = C_ESCAPE;
      end else if (b.lf) begin
        lf_end = 1'b1;
      end else begin
        cls = C_VALUE;
      end
      settled = 1'b1;
    end

    if (!settled && st.mode == M_DISCARD) begin
      if (b.cr) begin
        cls = C_LINEEND;
        if (has_next && nx.lf) begin
          st.mode = M_DISCARD_LF;
        end else begin
          done    = 1'b1;
          st.mode = M_START;
        end
      end else if (b.lf) begin
        cls     = C_LINEEND;
        done    = 1'b1;
        st.mode = M_START;
      end else begin
        cls = C_BAD;
      end
    end

    // LF in skip or value phase: fold if the next byte is blank
    if (lf_end) begin
      if (has_next && nx.blank) begin
        cls = C_FOLD;
      end else begin
        cls     = C_LINEEND;
        done    = 1'b1;
        st.mode = M_START;
      end
    end

    r.st   = st;
    r.cls  = cls;
    r.done = done;
    return r;
  endfunction

endpackage

// File: rtl/core/mhft_front.sv
// Front end: takes input bytes, decodes character kinds and queues them.
// Depends on mhft_pkg and the assertion macro header.
`include "mail_header_field_tokenizer_core_assert.svh"

module mhft_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          data_byte,
  input  logic                end_of_input,
  output mhft_pkg::q_head_t   head,
  input  logic                q_pop
);

  mhft_pkg::q_entry_t           mem [mhft_pkg::QDEPTH];
  logic [mhft_pkg::QAW-1:0]     wr_ptr;
  logic [mhft_pkg::QAW-1:0]     rd_ptr;
  logic [mhft_pkg::QCW-1:0]     count;
  logic                         wr_en;
  logic                         rd_en;

  assign full  = (count == mhft_pkg::QCW'(mhft_pkg::QDEPTH));
  assign wr_en = push && !full;
  assign rd_en = q_pop && head.valid;

  assign head.valid = (count != '0);
  assign head.entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr].data     <= data_byte;
      mem[wr_ptr].end_flag <= end_of_input;
      mem[wr_ptr].flags    <= mhft_pkg::decode_char(data_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  `MHFT_ASSERT_NEXT(a_full_holds, clk, rst, push && full && !q_pop, count == $past(count))
  `MHFT_ASSERT_IMPL(a_no_pop_when_empty, clk, rst, !head.valid, !q_pop)
  `MHFT_ASSERT_IMPL(a_full_has_head, clk, rst, full, head.valid)

endmodule

// File: rtl/core/mhft_back.sv
// Back end: runs the line parser over queued bytes with one byte of
// lookahead and queues the classified results. Depends on mhft_pkg.
`include "mail_header_field_tokenizer_core_assert.svh"

module mhft_back (
  input  logic              clk,
  input  logic              rst,
  input  mhft_pkg::q_head_t q_head,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_byte,
  output logic [2:0]        byte_class,
  output logic              field_done,
  output logic              last_result
);

  mhft_pkg::parse_state_t   st;
  mhft_pkg::parse_state_t   st_next;
  logic                     held_valid;
  logic [7:0]               held_data;
  mhft_pkg::char_flags_t    held_flags;
  logic                     flush_pending;

  mhft_pkg::class_result_t  res_a;
  mhft_pkg::class_result_t  res_f;

  mhft_pkg::result_t        omem [mhft_pkg::QDEPTH];
  logic [mhft_pkg::QAW-1:0] owr_ptr;
  logic [mhft_pkg::QAW-1:0] ord_ptr;
  logic [mhft_pkg::QCW-1:0] ocount;
  logic                     ofull;
  logic                     o_push;
  logic                     o_pop;
  mhft_pkg::result_t        o_din;
  logic                     flush_go;

  assign ofull = (ocount == mhft_pkg::QCW'(mhft_pkg::QDEPTH));

  // held byte with the queue head as lookahead, or alone on a flush
  assign res_a = mhft_pkg::classify(st, held_flags, 1'b1, q_head.entry.flags);
  assign res_f = mhft_pkg::classify(st, held_flags, 1'b0, '0);

  assign flush_go = flush_pending && !ofull;
  assign q_pop    = !flush_pending && q_head.valid && (!held_valid || !ofull);

  always_comb begin
    o_push  = 1'b0;
    o_din   = '0;
    st_next = st;
    if (flush_pending) begin
      o_push  = !ofull;
      o_din   = '{data: held_data, cls: res_f.cls, done: 1'b1, last: 1'b1};
      if (flush_go) st_next = mhft_pkg::ST_RESET;
    end else if (q_pop && held_valid) begin
      o_push  = 1'b1;
      o_din   = '{data: held_data, cls: res_a.cls, done: res_a.done, last: 1'b0};
      st_next = res_a.st;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      held_data  <= q_head.entry.data;
      held_flags <= q_head.entry.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= mhft_pkg::ST_RESET;
      held_valid    <= 1'b0;
      flush_pending <= 1'b0;
    end else begin
      st <= st_next;
      if (flush_go) begin
        held_valid    <= 1'b0;
        flush_pending <= 1'b0;
      end else if (q_pop) begin
        held_valid    <= 1'b1;
        flush_pending <= q_head.entry.end_flag;
      end
    end
  end

  // result queue
  assign empty = (ocount == '0);
  assign o_pop = pop && !empty;

  assign out_byte    = omem[ord_ptr].data;
  assign byte_class  = omem[ord_ptr].cls;
  assign field_done  = omem[ord_ptr].done;
  assign last_result = omem[ord_ptr].last;

  always_ff @(posedge clk) begin
    if (o_push) omem[owr_ptr] <= o_din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= '0;
      ord_ptr <= '0;
      ocount  <= '0;
    end else begin
      if (o_push) owr_ptr <= owr_ptr + 1'b1;
      if (o_pop)  ord_ptr <= ord_ptr + 1'b1;
      if (o_push && !o_pop) begin
        ocount <= ocount + 1'b1;
      end else if (o_pop && !o_push) begin
        ocount <= ocount - 1'b1;
      end
    end
  end

  `MHFT_ASSERT_IMPL(a_no_pop_in_flush, clk, rst, flush_pending, !q_pop)
  `MHFT_ASSERT_NEXT(a_end_sets_flush, clk, rst, q_pop && q_head.entry.end_flag, flush_pending)
  `MHFT_ASSERT_IMPL(a_last_is_done, clk, rst, !empty && last_result, field_done)

endmodule

// File: rtl/core/mail_header_field_tokenizer_core.sv
// Top level of the mail header field tokenizer.
// Depends on mhft_pkg, mhft_front and mhft_back.
//
//   channel  | direction | handshake      | payload
//   ---------+-----------+----------------+------------------------------------------
//   input    | in        | push / full    | data_byte, end_of_input
//   result   | out       | pop / empty    | out_byte, byte_class, field_done, last_result
//
// One byte per cycle sustained while the result queue has room; each byte
// leaves as a result once the next byte has reached the parser.
// A byte with end_of_input is flushed alone, without lookahead, before the next.
// Front and back each hold a four-entry queue, so either side stalls alone.
// rst is synchronous and returns the parser to line start with both queues empty.

module mail_header_field_tokenizer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_input,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [2:0] byte_class,
  output logic       field_done,
  output logic       last_result
);

  mhft_pkg::q_head_t q_head;
  logic              q_pop;

  mhft_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .end_of_input (end_of_input),
    .head         (q_head),
    .q_pop        (q_pop)
  );

  mhft_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .byte_class  (byte_class),
    .field_done  (field_done),
    .last_result (last_result)
  );

endmodule

// File: tb/sv/mail_header_field_tokenizer_core_tb.sv
// Testbench for mail_header_field_tokenizer_core: header byte streams in, classified bytes out.
// Depends on mhft_pkg for class codes and byte constants; predicts each token in a small class.
// Directed header lines first, then random lines, with random stalls on both queues.
module mail_header_field_tokenizer_core_tb;

  localparam int ITEM_TARGET    = 1850;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  // Tracks parser state and holds the tokens still owed by the block.
  class header_token_tracker;
    mhft_pkg::result_t expected_tokens[$];
    int unsigned       fails;
    logic [2:0]        mode;
    bit                quoted;
    bit                esc;
    logic [7:0]        held;
    bit                held_ok;
    logic [7:0]        prev_lbl;

    function new();
      fails = 0;
      restart();
    endfunction

    function void restart();
      mode     = mhft_pkg::M_START;
      quoted   = 1'b0;
      esc      = 1'b0;
      held     = 8'h00;
      held_ok  = 1'b0;
      prev_lbl = 8'h00;
    endfunction

    function bit is_space(logic [7:0] b);
      return b == mhft_pkg::CH_SPACE || (b >= mhft_pkg::CH_TAB && b <= mhft_pkg::CH_CR);
    endfunction

    function void classify_byte(input logic [7:0] b, input bit has_nx, input logic [7:0] nx,
                                output logic [2:0] cls, output bit done);
      bit settled;
      bit lf_hit;
      settled = 1'b0;
      lf_hit  = 1'b0;
      cls     = mhft_pkg::C_BAD;
      done    = 1'b0;
      // mode may hop several times before the byte is settled
      while (!settled) begin
        case (mode)
          mhft_pkg::M_START: begin
            quoted   = 1'b0;
            esc      = 1'b0;
            prev_lbl = 8'h00;
            mode     = is_space(b) ? mhft_pkg::M_DISCARD : mhft_pkg::M_LABEL;
          end
          mhft_pkg::M_LABEL: begin
            if (quoted) begin
              if (esc) begin
                esc = 1'b0;
                cls = mhft_pkg::C_LABEL;
              end else if (b == mhft_pkg::CH_BSLASH) begin
                esc = 1'b1;
                cls = mhft_pkg::C_ESCAPE;
              end else begin
                if (b == mhft_pkg::CH_QUOTE) quoted = 1'b0;
                cls = mhft_pkg::C_LABEL;
              end
              prev_lbl = b;
              settled  = 1'b1;
            end else if (is_space(b)) begin
              mode = (prev_lbl == mhft_pkg::CH_COLON) ? mhft_pkg::M_SKIP : mhft_pkg::M_DISCARD;
            end else begin
              if (b == mhft_pkg::CH_QUOTE) quoted = 1'b1;
              cls      = (b == mhft_pkg::CH_COLON && (!has_nx || is_space(nx))) ?
                         mhft_pkg::C_COLON : mhft_pkg::C_LABEL;
              prev_lbl = b;
              settled  = 1'b1;
            end
          end
          mhft_pkg::M_SKIP: begin
            if (b == mhft_pkg::CH_SPACE || b == mhft_pkg::CH_TAB || b == mhft_pkg::CH_CR) begin
              cls     = mhft_pkg::C_SKIP;
              settled = 1'b1;
            end else if (b == mhft_pkg::CH_LF) begin
              lf_hit  = 1'b1;
              settled = 1'b1;
            end else begin
              mode = mhft_pkg::M_VALUE;
            end
          end
          mhft_pkg::M_VALUE: begin
            if (esc) begin
              esc = 1'b0;
              cls = mhft_pkg::C_VALUE;
            end else if (b == mhft_pkg::CH_BSLASH) begin
              esc = 1'b1;
              cls = mhft_pkg::C_ESCAPE;
            end else if (b == mhft_pkg::CH_LF) begin
              lf_hit = 1'b1;
            end else begin
              cls = mhft_pkg::C_VALUE;
            end
            settled = 1'b1;
          end
          mhft_pkg::M_DISCARD: begin
            if (b == mhft_pkg::CH_CR) begin
              cls = mhft_pkg::C_LINEEND;
              if (has_nx && nx == mhft_pkg::CH_LF) begin
                mode = mhft_pkg::M_DISCARD_LF;
              end else begin
                done = 1'b1;
                mode = mhft_pkg::M_START;
              end
            end else if (b == mhft_pkg::CH_LF) begin
              cls  = mhft_pkg::C_LINEEND;
              done = 1'b1;
              mode = mhft_pkg::M_START;
            end else begin
              cls = mhft_pkg::C_BAD;
            end
            settled = 1'b1;
          end
          mhft_pkg::M_DISCARD_LF: begin
            if (b == mhft_pkg::CH_LF) begin
              cls     = mhft_pkg::C_LINEEND;
              done    = 1'b1;
              mode    = mhft_pkg::M_START;
              settled = 1'b1;
            end else begin
              mode = mhft_pkg::M_START;
            end
          end
          default: begin
            mode = mhft_pkg::M_START;
          end
        endcase
      end
      // LF in skip or value: fold only when a blank follows
      if (lf_hit) begin
        if (has_nx && (nx == mhft_pkg::CH_SPACE || nx == mhft_pkg::CH_TAB)) begin
          cls = mhft_pkg::C_FOLD;
        end else begin
          cls  = mhft_pkg::C_LINEEND;
          done = 1'b1;
          mode = mhft_pkg::M_START;
        end
      end
    endfunction

    function void note_byte(logic [7:0] b, bit e);
      logic [2:0] cls;
      bit         done;
      if (held_ok) begin
        classify_byte(held, 1'b1, b, cls, done);
        expected_tokens.push_back(mhft_pkg::result_t'{held, cls, done, 1'b0});
      end
      held    = b;
      held_ok = 1'b1;
      if (e) begin
        classify_byte(b, 1'b0, 8'h00, cls, done);
        expected_tokens.push_back(mhft_pkg::result_t'{b, cls, 1'b1, 1'b1});
        restart();
      end
    endfunction

    function void check_token(logic [7:0] ob, logic [2:0] cls, logic done, logic last);
      mhft_pkg::result_t want;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: out_byte %0h byte_class %0d", ob, cls);
        fails++;
        return;
      end
      want = expected_tokens.pop_front();
      if (ob !== want.data) begin
        $error("out_byte mismatch: expected %0h, actual %0h", want.data, ob);
        fails++;
      end
      if (cls !== want.cls) begin
        $error("byte_class mismatch: expected %0d, actual %0d", want.cls, cls);
        fails++;
      end
      if (done !== want.done) begin
        $error("field_done mismatch: expected %0b, actual %0b", want.done, done);
        fails++;
      end
      if (last !== want.last) begin
        $error("last_result mismatch: expected %0b, actual %0b", want.last, last);
        fails++;
      end
    endfunction
  endclass

  typedef struct {
    logic [7:0] b;
    bit         e;
  } hdr_byte_t;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       push         = 1'b0;
  logic       full;
  logic [7:0] data_byte    = 8'h00;
  logic       end_of_input = 1'b0;
  logic       empty;
  logic       pop          = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] byte_class;
  logic       field_done;
  logic       last_result;

  header_token_tracker tracker;
  hdr_byte_t           line_bytes[$];
  int                  sent       = 0;
  int                  quiet      = 0;
  int                  stall_left = 0;
  bit                  calm       = 1'b0;

  mail_header_field_tokenizer_core dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .end_of_input(end_of_input),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .byte_class  (byte_class),
    .field_done  (field_done),
    .last_result (last_result)
  );

  always #5 clk = ~clk;

  function void add_byte(logic [7:0] b);
    line_bytes.push_back('{b, 1'b0});
  endfunction

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h21, 8'hff));
    while (c == mhft_pkg::CH_COLON || c == mhft_pkg::CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == mhft_pkg::CH_LF || c == mhft_pkg::CH_BSLASH);
    return c;
  endfunction

  // space, tab, LF, VT, FF or CR
  function automatic logic [7:0] any_ws();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? mhft_pkg::CH_SPACE : mhft_pkg::CH_TAB + k[7:0];
  endfunction

  function automatic logic [7:0] blank();
    return $urandom_range(0, 1) ? mhft_pkg::CH_SPACE : mhft_pkg::CH_TAB;
  endfunction

  function void add_eol();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      add_byte(mhft_pkg::CH_CR);
      add_byte(mhft_pkg::CH_LF);
    end else if (r < 90) begin
      add_byte(mhft_pkg::CH_LF);
    end else begin
      add_byte(mhft_pkg::CH_CR);
    end
  endfunction

  function void add_quoted();
    logic [7:0] c;
    add_byte(mhft_pkg::CH_QUOTE);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 3) == 0) begin
        add_byte(mhft_pkg::CH_BSLASH);
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        do c = 8'($urandom_range(0, 255));
        while (c == mhft_pkg::CH_QUOTE || c == mhft_pkg::CH_BSLASH);
        add_byte(c);
      end
    end
    add_byte(mhft_pkg::CH_QUOTE);
  endfunction

  function void build_line();
    int unsigned kind;
    int unsigned r;
    line_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      repeat ($urandom_range(1, 5)) begin
        r = $urandom_range(0, 99);
        if (r < 10) add_quoted();
        else if (r < 14) add_byte(mhft_pkg::CH_COLON);
        else add_byte(label_char());
      end
      add_byte(mhft_pkg::CH_COLON);
      add_byte(($urandom_range(0, 99) < 85) ? blank() : any_ws());
      repeat ($urandom_range(0, 2)) begin
        r = $urandom_range(0, 2);
        add_byte(r == 0 ? mhft_pkg::CH_SPACE : (r == 1 ? mhft_pkg::CH_TAB : mhft_pkg::CH_CR));
      end
      if ($urandom_range(0, 9) == 0) begin
        add_byte(mhft_pkg::CH_LF);
        add_byte(blank());
      end
      repeat ($urandom_range(0, 12)) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          add_byte(mhft_pkg::CH_BSLASH);
          add_byte(8'($urandom_range(0, 255)));
        end else if (r < 14) begin
          add_byte(mhft_pkg::CH_LF);
          add_byte(blank());
        end else begin
          add_byte(value_char());
        end
      end
    end else if (kind < 80) begin
      // label ending on whitespace without a colon
      repeat ($urandom_range(1, 4)) add_byte(label_char());
      add_byte(any_ws());
      repeat ($urandom_range(0, 6)) add_byte(value_char());
    end else if (kind < 88) begin
      add_byte(any_ws());
      repeat ($urandom_range(0, 6)) add_byte(value_char());
    end else begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
    end
    if (kind < 88 || $urandom_range(0, 1)) add_eol();
  endfunction

  task automatic send_item(input logic [7:0] b, input bit e);
    calm <= (sent >= 800 && sent < 1150);
    if (!calm && $urandom_range(0, 99) < 6) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push         <= 1'b1;
    data_byte    <= b;
    end_of_input <= e;
    do @(posedge clk); while (full);
    tracker.note_byte(b, e);
    sent++;
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_item(line_bytes[i].b, line_bytes[i].e);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) tracker.check_token(out_byte, byte_class, field_done, last_result);
      if (stall_left == 0 && !calm && $urandom_range(0, 99) < 3) stall_left = $urandom_range(1, 6);
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // counts cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned r;
    tracker = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // one-byte buffer straight after reset
    line_bytes.delete();
    add_byte(8'hff);
    line_bytes[$].e = 1'b1;
    send_line();

    // quoted label with escape, folds in skip and value, discarded lines
    line_bytes.delete();
    add_text("a\\:\"\\\"\":");
    add_byte(mhft_pkg::CH_SPACE);
    add_byte(mhft_pkg::CH_CR);
    add_byte(mhft_pkg::CH_LF);
    add_byte(mhft_pkg::CH_TAB);
    add_text("v\\");
    add_byte(mhft_pkg::CH_LF);
    add_byte(mhft_pkg::CH_CR);
    add_byte(8'h00);
    add_byte(mhft_pkg::CH_LF);
    add_byte(mhft_pkg::CH_SPACE);
    add_byte(mhft_pkg::CH_LF);
    add_text("x ");
    add_byte(mhft_pkg::CH_CR);
    add_byte(mhft_pkg::CH_LF);
    add_byte(mhft_pkg::CH_SPACE);
    add_byte(mhft_pkg::CH_CR);
    add_text("z:");
    add_byte(mhft_pkg::CH_LF);
    line_bytes[$].e = 1'b1;
    send_line();

    while (sent < ITEM_TARGET) begin
      build_line();
      r = $urandom_range(0, 99);
      if (r < 6 || sent + line_bytes.size() >= ITEM_TARGET) begin
        line_bytes[$].e = 1'b1;
      end else if (r < 8) begin
        line_bytes[$urandom_range(0, line_bytes.size() - 1)].e = 1'b1;
      end else if (r < 10) begin
        line_bytes.push_back('{8'($urandom_range(0, 255)), 1'b1});
      end
      send_line();
    end
    push <= 1'b0;

    while (tracker.expected_tokens.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/mhft_pkg.sv
rtl/core/mhft_front.sv
rtl/core/mhft_back.sv
rtl/core/mail_header_field_tokenizer_core.sv
tb/sv/mail_header_field_tokenizer_core_tb.sv
